// File: src/addressed_crc8_frame_receiver_assert.svh
// assertion macros shared by the frame receiver modules
`ifndef ADDRESSED_CRC8_FRAME_RECEIVER_ASSERT_SVH
`define ADDRESSED_CRC8_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ACFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define ACFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/acfr_pkg.sv
`default_nettype none

package acfr_pkg;

  // frame geometry
  localparam int FRAME_LEN = 24;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int IDX_W     = 5;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

  // crc-8, polynomial x^8 + x^2 + x + 1, no reflection
  localparam logic [7:0] CRC_POLY = 8'h07;

  // controller to datapath commands
  typedef struct packed {
    logic store;    // write the input byte at the fill position
    logic finish;   // clear fill count and crc after the final byte
    logic rd_en;    // read the frame store at the replay index
    logic rd_next;  // step the replay index, wrapping after the last byte
  } acfr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_zero;   // no frame open
    logic addr_match;  // input byte equals the device address
    logic at_last;     // next stored byte is the crc byte
    logic crc_ok;      // input byte equals the running crc
    logic rd_last;     // replay index is on the crc byte
  } acfr_status_t;

  // one byte of the crc, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/addressed_crc8_frame_receiver.sv
// channel  | direction | signals                        | content
// s_axis   | in        | tvalid tready tdata[7:0]       | received byte
// m_axis   | out       | tvalid tready tdata[15:0] tlast| byte of a frame that passed crc
// cfg      | in        | valid ready data[7:0]          | device address
//
// one received byte is taken per cycle while no replay is running
// a good frame is replayed byte by byte through a read state, which registers the
// frame store read, and a show state; input is held off during the replay
// output stalls hold the replay; the cfg port is always ready
// rst is synchronous: address returns to 1 and the block waits for an address byte
`default_nettype none

module addressed_crc8_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] frame_byte, [12:8] byte_index
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  acfr_pkg::acfr_cmd_t    cmd;
  acfr_pkg::acfr_status_t st;
  logic [7:0]                 frame_byte;
  logic [acfr_pkg::IDX_W-1:0] byte_index;

  // controller
  acfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  acfr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .rx_byte    (s_axis_tdata),
    .cmd        (cmd),
    .st         (st),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (m_axis_tlast)
  );

  // output packing, pad bits zero
  assign m_axis_tdata = {3'b000, byte_index, frame_byte};
  assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// File: src/acfr_ctrl.sv
`default_nettype none

`include "addressed_crc8_frame_receiver_assert.svh"

module acfr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire acfr_pkg::acfr_status_t st,
  output acfr_pkg::acfr_cmd_t       cmd
);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_RECV: begin
        if (in_valid && (!st.fill_zero || st.addr_match)) begin
          cmd.store = 1'b1;
          if (st.at_last) begin
            cmd.finish = 1'b1;
            if (st.crc_ok) begin
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          cmd.rd_next = 1'b1;
          state_next  = st.rd_last ? S_RECV : S_READ;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

  // handshake outputs
  assign in_ready  = (state == S_RECV);
  assign out_valid = (state == S_SHOW);

  // checks
  `ACFR_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken during replay")
  `ACFR_ASSERT_NEXT(a_good_frame_replays, in_valid && in_ready && st.at_last && st.crc_ok, state == S_READ, "good frame not replayed")
  `ACFR_ASSERT_NEXT(a_replay_ends, out_valid && out_ready && st.rd_last, in_ready, "no return to receive after replay")

endmodule

`default_nettype wire

// File: src/acfr_datapath.sv
`default_nettype none

`include "addressed_crc8_frame_receiver_assert.svh"

module acfr_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [7:0]             cfg_data,
  input  wire logic [7:0]             rx_byte,
  input  wire acfr_pkg::acfr_cmd_t    cmd,
  output acfr_pkg::acfr_status_t      st,
  output logic [7:0]                  frame_byte,
  output logic [acfr_pkg::IDX_W-1:0]  byte_index,
  output logic                        last
);

  logic [7:0]                 device_address;
  logic [acfr_pkg::CNT_W-1:0] fill_count;
  logic [7:0]                 running_crc;
  logic [acfr_pkg::CNT_W-1:0] rd_idx;
  logic [7:0]                 rd_q;
  logic [7:0]                 frame_store [acfr_pkg::FRAME_LEN];
  logic [acfr_pkg::CNT_W+acfr_pkg::IDX_W-1:0] idx_ext;

  // device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg_we) begin
      device_address <= cfg_data;
    end
  end

  // fill count and running crc
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      running_crc <= '0;
    end else if (cmd.store) begin
      if (cmd.finish) begin
        fill_count  <= '0;
        running_crc <= '0;
      end else begin
        fill_count  <= fill_count + 1'b1;
        running_crc <= acfr_pkg::crc8_update(running_crc, rx_byte);
      end
    end
  end

  // replay index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= st.rd_last ? '0 : rd_idx + 1'b1;
    end
  end

  // frame store write port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      frame_store[fill_count] <= rx_byte;
    end
  end

  // frame store registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= frame_store[rd_idx];
    end
  end

  // status to the controller
  assign st.fill_zero  = (fill_count == '0);
  assign st.addr_match = (rx_byte == device_address);
  assign st.at_last    = (fill_count == acfr_pkg::LAST_POS);
  assign st.crc_ok     = (rx_byte == running_crc);
  assign st.rd_last    = (rd_idx == acfr_pkg::LAST_POS);

  // result fields, index cut to the field width
  assign idx_ext    = {{acfr_pkg::IDX_W{1'b0}}, rd_idx};
  assign frame_byte = rd_q;
  assign byte_index = idx_ext[acfr_pkg::IDX_W-1:0];
  assign last       = st.rd_last;

  // checks
  `ACFR_ASSERT_NOW(a_idle_crc_clear, fill_count == '0, running_crc == 8'd0, "crc not clear while idle")

endmodule

`default_nettype wire
